@@ rtl/dwp_pkg.sv @@
// Shared constants and controller/datapath interface types for the draw pool.
package dwp_pkg;

    localparam int POOL_DEPTH   = 64;
    localparam int RANDOM_WIDTH = 32;

    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
    localparam int BIT_W  = $clog2(RANDOM_WIDTH);
    localparam int SIZE_W = 7;
    localparam int RWORD_W = 32;
    localparam int INDEX_OUT_W = 6;

    localparam int S_TDATA_W = ((SIZE_W + RWORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((INDEX_OUT_W + 7) / 8) * 8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic STATUS_DRAWN = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_step;
        logic read;
        logic finish;
    } dwp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic div_done;
        logic out_free;
    } dwp_sts_t;

endpackage

@@ rtl/dwp_ctrl.sv @@
// Sequencing state machine for the draw pool: accept, check, divide, read, retire.
module dwp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dwp_pkg::dwp_sts_t sts,
    output dwp_pkg::dwp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_READ,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.count_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/dwp_datapath.sv @@
// Pool store, live count, serial remainder unit and output register of the draw pool.
module dwp_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dwp_pkg::dwp_cmd_t                   cmd,
    output dwp_pkg::dwp_sts_t                   sts,
    input  logic                                in_command,
    input  logic [dwp_pkg::SIZE_W-1:0]          in_pool_size,
    input  logic [dwp_pkg::RWORD_W-1:0]         in_random_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dwp_pkg::INDEX_OUT_W-1:0]     out_drawn_index,
    output logic                                out_status
);

    localparam int IDX_W = dwp_pkg::IDX_W;
    localparam int CNT_W = dwp_pkg::CNT_W;
    localparam int RW    = dwp_pkg::RANDOM_WIDTH;

    logic [CNT_W-1:0]            count_reg;
    logic [RW-1:0]               rnd_reg;
    logic [CNT_W-1:0]            rem_reg;
    logic [dwp_pkg::BIT_W-1:0]   bit_cnt_reg;
    logic [dwp_pkg::POOL_DEPTH-1:0] valid_reg;
    logic [IDX_W-1:0]            mem [dwp_pkg::POOL_DEPTH];
    logic [IDX_W-1:0]            rd_pos_mem_reg;
    logic [IDX_W-1:0]            rd_last_mem_reg;
    logic                        rd_pos_valid_reg;
    logic                        rd_last_valid_reg;
    logic [IDX_W-1:0]            rd_last_idx_reg;
    logic                        out_valid_reg;
    logic [dwp_pkg::INDEX_OUT_W-1:0] out_index_reg;
    logic                        out_status_reg;

    logic [CNT_W:0]              trial;
    logic [CNT_W-1:0]            rem_next;
    logic [IDX_W-1:0]            pos;
    logic [IDX_W-1:0]            last_idx;
    logic [IDX_W-1:0]            rd_pos_val;
    logic [IDX_W-1:0]            rd_last_val;
    logic [CNT_W-1:0]            load_count;
    logic                        count_zero;
    logic                        out_free;

    assign count_zero = (count_reg == '0);
    assign out_free   = !out_valid_reg || out_ready;
    assign pos        = rem_reg[IDX_W-1:0];
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign trial      = {rem_reg, rnd_reg[RW-1]};
    assign rem_next   = (trial >= {1'b0, count_reg}) ? CNT_W'(trial - {1'b0, count_reg})
                                                      : CNT_W'(trial);
    assign load_count = (32'(in_pool_size) > 32'(dwp_pkg::POOL_DEPTH))
                        ? CNT_W'(dwp_pkg::POOL_DEPTH) : CNT_W'(in_pool_size);
    assign rd_pos_val  = rd_pos_valid_reg ? rd_pos_mem_reg : pos;
    assign rd_last_val = rd_last_valid_reg ? rd_last_mem_reg : rd_last_idx_reg;

    assign sts.count_zero = count_zero;
    assign sts.div_done   = (bit_cnt_reg == dwp_pkg::BIT_W'(RW - 1));
    assign sts.out_free   = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture && (in_command == dwp_pkg::CMD_LOAD))
            begin
                count_reg <= load_count;
                valid_reg <= '0;
            end
            else if (cmd.finish && !count_zero)
            begin
                count_reg      <= count_reg - CNT_W'(1);
                valid_reg[pos] <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rnd_reg <= RW'(in_random_word);
        end
        else if (cmd.div_step)
        begin
            rnd_reg <= rnd_reg << 1;
        end
        if (cmd.div_start)
        begin
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_reg + dwp_pkg::BIT_W'(1);
        end
        if (cmd.read)
        begin
            rd_pos_mem_reg    <= mem[pos];
            rd_last_mem_reg   <= mem[last_idx];
            rd_pos_valid_reg  <= valid_reg[pos];
            rd_last_valid_reg <= valid_reg[last_idx];
            rd_last_idx_reg   <= last_idx;
        end
        if (cmd.finish && !count_zero)
        begin
            mem[pos] <= rd_last_val;
        end
        if (cmd.finish)
        begin
            out_index_reg  <= count_zero ? '0 : dwp_pkg::INDEX_OUT_W'(rd_pos_val);
            out_status_reg <= count_zero ? dwp_pkg::STATUS_EMPTY : dwp_pkg::STATUS_DRAWN;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_drawn_index = out_index_reg;
    assign out_status      = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= dwp_pkg::POOL_DEPTH)
        else $error("live count exceeds pool depth");

    a_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < count_reg))
        else $error("partial remainder not below live count");

    a_finish_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !count_zero) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("draw did not decrement live count");

    a_finish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> out_free)
        else $error("result retired while output register busy");
`endif

endmodule

@@ rtl/draw_without_replacement_pool.sv @@
// Top level of the draw-without-replacement pool: stream ports, controller and datapath.
//
//  Channel   Dir  tdata (low bit up)                       tuser
//  s_axis    in   pool_size[6:0], random_word[38:7], pad   command
//  m_axis    out  drawn_index[5:0], pad                    status
//
// Each item passes from acceptance to a result through a capture state, a count
// check, the steps of the bit-serial remainder unit (one per random-word bit), a pool
// read and a retire state. An empty pool skips the remainder and read.
// A load clears the per-entry valid flags at once; no clearing pass is needed.
// A result waiting in the output register does not block acceptance; only retire stalls.
module draw_without_replacement_pool
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dwp_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // pool_size, random_word
    input  logic                            s_axis_tuser,  // command
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dwp_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // drawn_index
    output logic                            m_axis_tuser   // status
);

    dwp_pkg::dwp_cmd_t                      cmd;
    dwp_pkg::dwp_sts_t                      sts;
    logic [dwp_pkg::INDEX_OUT_W-1:0]        drawn_index;

    dwp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dwp_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_command      (s_axis_tuser),
        .in_pool_size    (s_axis_tdata[dwp_pkg::SIZE_W-1:0]),
        .in_random_word  (s_axis_tdata[dwp_pkg::SIZE_W +: dwp_pkg::RWORD_W]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_drawn_index (drawn_index),
        .out_status      (m_axis_tuser)
    );

    assign m_axis_tdata = dwp_pkg::M_TDATA_W'(drawn_index);

endmodule
